/* rtl/hkr_pkg.sv */
// ----------------------------------------------------------------------------
// hkr_pkg
// Shared types, constants and usage helpers for the keyboard report to
// key event converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hkr_pkg;

    // key slots kept between reports
    localparam int KEY_SLOTS = 6;
    // key fields present in one input item
    localparam int KEY_FIELDS = 6;
    // slots actually carried from a report
    localparam int KEY_LIMIT = (KEY_SLOTS < KEY_FIELDS) ? KEY_SLOTS : KEY_FIELDS;
    // modifier bits in a report
    localparam int MOD_BITS = 8;
    // candidate events per report: modifiers, releases, presses
    localparam int EV_SLOTS = MOD_BITS + 2 * KEY_SLOTS;
    // entries of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // stream widths
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 16;

    localparam logic [7:0] MOD_USAGE_BASE = 8'hE0;
    // left gui, right ctrl, right alt and right gui are extended
    localparam logic [MOD_BITS-1:0] MOD_EXT = 8'b1101_1000;

    // usage range bounds
    localparam logic [7:0] USG_LETTER_A   = 8'h04;
    localparam logic [7:0] USG_LOW_END    = 8'h31;
    localparam logic [7:0] USG_NON_US     = 8'h32;
    localparam logic [7:0] USG_MID_START  = 8'h33;
    localparam logic [7:0] USG_MID_END    = 8'h45;
    localparam logic [7:0] USG_INSERT     = 8'h49;
    localparam logic [7:0] USG_KP_DIVIDE  = 8'h54;
    localparam logic [7:0] USG_HIGH_END   = 8'h63;

    typedef logic [7:0] usage_t;
    typedef logic [KEY_SLOTS-1:0][7:0] key_set_t;

    // one classified report waiting for the back end
    typedef struct packed {
        logic [EV_SLOTS-1:0]  mask;
        logic [MOD_BITS-1:0]  mods;
        key_set_t             old_keys;
        key_set_t             new_keys;
    } job_t;

    // usage produces an event at all
    function automatic logic usage_mapped(input usage_t u);
        logic m;
        m = ((u >= USG_LETTER_A) && (u <= USG_LOW_END))
         || ((u >= USG_MID_START) && (u <= USG_MID_END))
         || ((u >= USG_INSERT) && (u <= USG_HIGH_END));
        return m;
    endfunction

    // insert through keypad divide
    function automatic logic usage_extended(input usage_t u);
        logic e;
        e = (u >= USG_INSERT) && (u <= USG_KP_DIVIDE);
        return e;
    endfunction

endpackage

`default_nettype wire

/* rtl/hkr_front.sv */
// ----------------------------------------------------------------------------
// hkr_front
// Accepts reports, compares them with the stored report and queues a job
// holding a mask of the events that the report causes.
// ----------------------------------------------------------------------------
`default_nettype none

module hkr_front (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // modifiers, key_a .. key_f, key_count, zero pad
    input  wire logic [hkr_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                     q_full,
    output logic                          q_push,
    output hkr_pkg::job_t                 q_job
);

    localparam logic [2:0] N_LIM = 3'(hkr_pkg::KEY_LIMIT);

    logic [hkr_pkg::MOD_BITS-1:0]     prev_mods_reg;
    logic [hkr_pkg::MOD_BITS-1:0]     prev_mods_next;
    hkr_pkg::key_set_t                prev_keys_reg;
    hkr_pkg::key_set_t                prev_keys_next;

    logic [hkr_pkg::KEY_FIELDS-1:0][7:0] in_keys;
    logic [hkr_pkg::MOD_BITS-1:0]     in_mods;
    logic [2:0]                       in_count;
    logic [2:0]                       n_cnt;
    hkr_pkg::key_set_t                nk;
    logic [hkr_pkg::EV_SLOTS-1:0]     mask;
    logic                             accept;

    // unpack the input item
    always_comb begin
        in_mods  = s_tdata[7:0];
        for (int f = 0; f < hkr_pkg::KEY_FIELDS; f++) begin
            in_keys[f] = s_tdata[8*(f+1) +: 8];
        end
        in_count = s_tdata[8*(hkr_pkg::KEY_FIELDS+1) +: 3];
        n_cnt    = (in_count > N_LIM) ? N_LIM : in_count;
    end

    // new key set, slots past the count read as empty
    always_comb begin
        for (int i = 0; i < hkr_pkg::KEY_SLOTS; i++) begin
            nk[i] = 8'h00;
            if ((i < hkr_pkg::KEY_FIELDS) && (i < int'(n_cnt))) begin
                nk[i] = in_keys[i];
            end
        end
    end

    // classify: changed modifiers, released keys, pressed keys
    always_comb begin
        logic hit;
        mask = '0;
        for (int b = 0; b < hkr_pkg::MOD_BITS; b++) begin
            mask[b] = prev_mods_reg[b] ^ in_mods[b];
        end
        for (int i = 0; i < hkr_pkg::KEY_SLOTS; i++) begin
            hit = 1'b0;
            for (int j = 0; j < hkr_pkg::KEY_SLOTS; j++) begin
                hit = hit | (nk[j] == prev_keys_reg[i]);
            end
            mask[hkr_pkg::MOD_BITS + i] = (prev_keys_reg[i] != 8'h00) && !hit
                                        && hkr_pkg::usage_mapped(prev_keys_reg[i]);
        end
        for (int j = 0; j < hkr_pkg::KEY_SLOTS; j++) begin
            hit = 1'b0;
            for (int i = 0; i < hkr_pkg::KEY_SLOTS; i++) begin
                hit = hit | (prev_keys_reg[i] == nk[j]);
            end
            mask[hkr_pkg::MOD_BITS + hkr_pkg::KEY_SLOTS + j] =
                (nk[j] != 8'h00) && !hit && hkr_pkg::usage_mapped(nk[j]);
        end
    end

    // handshake and queue write
    always_comb begin
        s_tready          = !q_full;
        accept            = s_tvalid && !q_full;
        q_push            = accept && (mask != '0);
        q_job.mask        = mask;
        q_job.mods        = in_mods;
        q_job.old_keys    = prev_keys_reg;
        q_job.new_keys    = nk;
        prev_mods_next    = accept ? in_mods : prev_mods_reg;
        prev_keys_next    = accept ? nk : prev_keys_reg;
    end

    // stored report
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_mods_reg <= '0;
            prev_keys_reg <= '0;
        end else begin
            prev_mods_reg <= prev_mods_next;
            prev_keys_reg <= prev_keys_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/hkr_fifo.sv */
// ----------------------------------------------------------------------------
// hkr_fifo
// Short job queue between the classifying front end and the event back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hkr_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire hkr_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               not_empty,
    output hkr_pkg::job_t      head_job
);

    localparam int PTR_W = (hkr_pkg::QUEUE_DEPTH > 1) ? $clog2(hkr_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(hkr_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(hkr_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(hkr_pkg::QUEUE_DEPTH);

    hkr_pkg::job_t        entry_reg [hkr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    // status and pointer updates
    always_comb begin
        full        = (count_reg == CNT_FULL);
        not_empty   = (count_reg != '0);
        head_job    = entry_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("job queue read while empty");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("job queue count out of range");

endmodule

`default_nettype wire

/* rtl/hkr_back.sv */
// ----------------------------------------------------------------------------
// hkr_back
// Walks the event mask of each queued job, lowest slot first, and drives one
// key event per cycle into the output register while it is free or m_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module hkr_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_not_empty,
    input  wire hkr_pkg::job_t q_head,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // usage, pressed, extended, zero pad
    output logic [hkr_pkg::M_DATA_W-1:0] m_tdata,
    output logic               m_tlast
);

    localparam int REL_BASE = hkr_pkg::MOD_BITS;
    localparam int PRS_BASE = hkr_pkg::MOD_BITS + hkr_pkg::KEY_SLOTS;

    hkr_pkg::job_t                 job_reg;
    hkr_pkg::job_t                 job_next;
    logic                          valid_reg;
    logic                          valid_next;
    logic [7:0]                    usage_reg;
    logic                          pressed_reg;
    logic                          ext_reg;
    logic                          last_reg;

    logic [hkr_pkg::EV_SLOTS-1:0]  pick;
    logic [hkr_pkg::EV_SLOTS-1:0]  rest;
    logic [7:0]                    sel_usage;
    logic                          sel_pressed;
    logic                          sel_ext;
    logic                          emit;
    logic                          found;

    // lowest pending event and its fields
    always_comb begin
        pick        = '0;
        found       = 1'b0;
        sel_usage   = 8'h00;
        sel_pressed = 1'b0;
        sel_ext     = 1'b0;
        for (int s = 0; s < hkr_pkg::EV_SLOTS; s++) begin
            if (job_reg.mask[s] && !found) begin
                found   = 1'b1;
                pick[s] = 1'b1;
                if (s < REL_BASE) begin
                    sel_usage   = hkr_pkg::MOD_USAGE_BASE | 8'(s);
                    sel_pressed = job_reg.mods[s];
                    sel_ext     = hkr_pkg::MOD_EXT[s];
                end else if (s < PRS_BASE) begin
                    sel_usage   = job_reg.old_keys[s - REL_BASE];
                    sel_pressed = 1'b0;
                    sel_ext     = hkr_pkg::usage_extended(sel_usage);
                end else begin
                    sel_usage   = job_reg.new_keys[s - PRS_BASE];
                    sel_pressed = 1'b1;
                    sel_ext     = hkr_pkg::usage_extended(sel_usage);
                end
            end
        end
        rest = job_reg.mask & ~pick;
    end

    // emit when the output slot frees; fetch a job on the last event or when idle
    always_comb begin
        emit       = found && (!valid_reg || m_tready);
        q_pop      = q_not_empty && (!found || (emit && (rest == '0)));
        job_next   = job_reg;
        if (emit) begin
            job_next.mask = rest;
        end
        if (q_pop) begin
            job_next = q_head;
        end
        valid_next = valid_reg;
        if (emit) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    // control state and current job
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_reg.mask <= '0;
            valid_reg    <= 1'b0;
        end else begin
            job_reg      <= job_next;
            valid_reg    <= valid_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (emit) begin
            usage_reg   <= sel_usage;
            pressed_reg <= sel_pressed;
            ext_reg     <= sel_ext;
            last_reg    <= (rest == '0);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(hkr_pkg::M_DATA_W - 10){1'b0}}, ext_reg, pressed_reg, usage_reg};
    assign m_tlast  = last_reg;

    a_job_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (job_reg.mask != '0))
        else $error("back end loaded a job without events");

    a_pending_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (found && !valid_reg) |=> valid_reg)
        else $error("pending event not moved to the output register");

endmodule

`default_nettype wire

/* rtl/hid_keyboard_report_to_key_events.sv */
// ----------------------------------------------------------------------------
// hid_keyboard_report_to_key_events
// Converts boot-keyboard reports into a stream of key change events.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one report per item: modifier byte, six key usages and
//   a key count. The previous report is kept inside the block.
//   m_ channel gives one key event per item: usage, pressed, extended, with
//   m_tlast on the final event of a report. Order: changed modifier bits
//   (usages 0xe0..0xe7), then released keys, then pressed keys.
//   A report equal to the stored one gives no events at all.
// Data flow:
//   A report's first event passes a queue entry and the back end's job
//   register to reach the output register. Events leave one per cycle while
//   m_tready does not stall them; a report gives up to 20 events. Reports
//   are taken every cycle while the two-entry job queue has room.
// Reset:
//   aresetn low clears the stored report to all keys up and no modifiers
//   and empties the queue and the output register.
// Stall:
//   a low m_tready holds the current event; the back end waits, the queue
//   fills and then s_tready drops until space frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module hid_keyboard_report_to_key_events (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // modifiers, key_a, key_b, key_c, key_d, key_e, key_f, key_count, zero pad
    input  wire logic [hkr_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // usage, pressed, extended, zero pad
    output logic [hkr_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                               m_tlast
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_not_empty;
    hkr_pkg::job_t  q_in_job;
    hkr_pkg::job_t  q_head_job;

    // report intake and classification
    hkr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_in_job)
    );

    // job queue
    hkr_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (q_in_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_job  (q_head_job)
    );

    // event sequencing and output register
    hkr_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head_job),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire
